// File: sv/tps_pkg.sv
// Shared types, constants and the logarithm table for the thin plate spline evaluator.
// Has no dependencies. Every other file of the block refers to it by scoped names.
`default_nettype none

package tps_pkg;

   // Sizes of the control point store and of the fixed-point format.
   localparam int MAX_POINTS        = 32;
   localparam int ADDR_W            = $clog2(MAX_POINTS);
   localparam int CNT_W             = 6;
   localparam int FRAC_BITS         = 16;
   localparam int LOG_TABLE_ENTRIES = 256;
   localparam int LOG_IDX_W         = $clog2(LOG_TABLE_ENTRIES);
   localparam int COORD_W           = 18;
   localparam int COEF_W            = 24;
   localparam int DIFF_W            = COORD_W + 1;
   localparam int D_W               = 2 * COORD_W + 2;
   localparam int NORM_W            = 40;
   localparam int LG_W              = 37;
   localparam int LN_W              = 24;
   localparam int MAG_W             = 26;
   localparam int U_W               = MAG_W + 1;
   localparam int ACC_W             = 48;
   localparam int OUT_W             = 32;
   localparam int STEP_W            = 4;

   // ln(2) in Q.24.
   localparam logic [COEF_W-1:0] LN2_Q24 = 24'd11629080;

   // Sequencer steps of one control point.
   localparam logic [STEP_W-1:0] STEP_U0   = 4'd8;
   localparam logic [STEP_W-1:0] STEP_LAST = 4'd9;

   // Input item modes.
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_EVAL = 1'b1;

   // Configuration register indexes.
   localparam logic [2:0] REG_OFFSET  = 3'd0;
   localparam logic [2:0] REG_GAIN_X  = 3'd1;
   localparam logic [2:0] REG_GAIN_Y  = 3'd2;
   localparam logic [2:0] REG_POINTS  = 3'd3;
   localparam logic [2:0] REG_REDUCED = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AFF_MUL,
      ST_AFF_SUM,
      ST_POINT,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              take;
      logic              mem_wr;
      logic [ADDR_W-1:0] rd_addr;
      logic              acc_init;
      logic              u0_load;
      logic              acc_add;
      logic              out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
   } status_type;

   typedef logic [29:0] log_tab_type [LOG_TABLE_ENTRIES];

   // log2(1 + k/LOG_TABLE_ENTRIES) in Q.30, bit by bit through repeated squaring.
   function automatic log_tab_type build_log_tab();
      log_tab_type t;
      logic [63:0] x;
      logic [29:0] r;
      int          k;
      int          b;
      for (k = 0; k < LOG_TABLE_ENTRIES; k++) begin
         x = ((64'(LOG_TABLE_ENTRIES) + 64'(k)) << 30) / 64'(LOG_TABLE_ENTRIES);
         r = '0;
         for (b = 30; b > 0; b--) begin
            x = (x * x) >> 30;
            if (x >= (64'd2 << 30)) begin
               r[b-1] = 1'b1;
               x = x >> 1;
            end
         end
         t[k] = r;
      end
      return t;
   endfunction

   localparam log_tab_type LOG_TAB = build_log_tab();

endpackage

`default_nettype wire

// File: sv/tps_datapath.sv
// Datapath of the thin plate spline evaluator: control point store, basis term unit, accumulator.
// Depends on tps_pkg; driven by commands from tps_ctrl.
`default_nettype none

module tps_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire tps_pkg::cmd_type                  cmd,
   output tps_pkg::status_type                    status,
   input  wire logic [tps_pkg::ADDR_W-1:0]        wr_addr,
   input  wire logic signed [tps_pkg::COORD_W-1:0] in_x,
   input  wire logic signed [tps_pkg::COORD_W-1:0] in_y,
   input  wire logic signed [tps_pkg::COEF_W-1:0] in_weight,
   input  wire logic signed [tps_pkg::COEF_W-1:0] cfg_offset,
   input  wire logic signed [tps_pkg::COEF_W-1:0] cfg_gain_x,
   input  wire logic signed [tps_pkg::COEF_W-1:0] cfg_gain_y,
   input  wire logic                              out_stall,
   output logic                                   out_valid,
   output logic signed [tps_pkg::OUT_W-1:0]       out_value,
   output logic                                   out_saturated
);

   localparam int MEM_W = 2 * tps_pkg::COORD_W + tps_pkg::COEF_W;

   // Control point store: x, y and weight in one word.
   logic [MEM_W-1:0] mem [tps_pkg::MAX_POINTS];
   logic [MEM_W-1:0] mem_q_ff;

   logic signed [tps_pkg::COORD_W-1:0] x_ff, y_ff;
   logic signed [tps_pkg::COORD_W+tps_pkg::COEF_W-1:0] px_ff, py_ff;
   logic [tps_pkg::D_W-2:0]          dx2_ff, dy2_ff;
   logic [tps_pkg::D_W-1:0]          d_ff;
   logic [tps_pkg::NORM_W-1:0]       m1_ff, m1_in;
   logic [2:0]                       g_ff, g_in;
   logic                             zero_ff;
   logic [5:0]                       p_ff, p_in;
   logic [tps_pkg::LOG_IDX_W-1:0]    idx_ff, idx_in;
   logic signed [tps_pkg::LG_W+tps_pkg::COEF_W:0] lgp_ff;
   logic [44:0]                      dhl_ff;
   logic [38:0]                      dll_ff;
   logic                             lneg_ff;
   logic signed [tps_pkg::U_W-1:0]   u_ff, u_in, u0_ff;
   logic signed [tps_pkg::COEF_W+tps_pkg::U_W:0] term_ff;
   logic signed [tps_pkg::ACC_W-1:0] acc_ff;
   logic                             out_valid_ff;
   logic signed [tps_pkg::OUT_W-1:0] out_value_ff, out_value_in;
   logic                             out_sat_ff, out_sat_in;

   logic signed [tps_pkg::COORD_W-1:0] cx, cy;
   logic signed [tps_pkg::COEF_W-1:0]  cw;
   logic signed [tps_pkg::DIFF_W-1:0]  dx, dy;
   logic signed [2*tps_pkg::DIFF_W-1:0] dx2_full, dy2_full;
   logic [tps_pkg::NORM_W-1:0]         d40;
   logic [tps_pkg::NORM_W-1:0]         mn;
   logic [2:0]                         j;
   logic signed [6:0]                  pm;
   logic signed [tps_pkg::LG_W-1:0]    lg;
   logic signed [tps_pkg::LN_W-1:0]    ln;
   logic [tps_pkg::LN_W-2:0]           lmag;
   logic [45:0]                        mag_sum;
   logic [tps_pkg::MAG_W-1:0]          mag;
   logic signed [tps_pkg::U_W:0]       udiff;
   logic signed [tps_pkg::ACC_W-1:0]   aff_sum;

   assign cx = mem_q_ff[MEM_W-1 -: tps_pkg::COORD_W];
   assign cy = mem_q_ff[tps_pkg::COEF_W +: tps_pkg::COORD_W];
   assign cw = mem_q_ff[tps_pkg::COEF_W-1:0];

   // Store writes and registered reads.
   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         mem[wr_addr] <= {in_x, in_y, in_weight};
      end
      mem_q_ff <= mem[cmd.rd_addr];
   end

   // Squared distance.
   always_comb begin
      dx       = DIFF_W_sub(x_ff, cx);
      dy       = DIFF_W_sub(y_ff, cy);
      dx2_full = dx * dx;
      dy2_full = dy * dy;
   end

   function automatic logic signed [tps_pkg::DIFF_W-1:0] DIFF_W_sub(
      input logic signed [tps_pkg::COORD_W-1:0] a,
      input logic signed [tps_pkg::COORD_W-1:0] b
   );
      return tps_pkg::DIFF_W'(a) - tps_pkg::DIFF_W'(b);
   endfunction

   // Coarse normalization: find the top nonzero byte.
   always_comb begin
      d40 = tps_pkg::NORM_W'(d_ff);
      if (|d40[39:32]) begin
         g_in  = 3'd4;
         m1_in = d40;
      end else if (|d40[31:24]) begin
         g_in  = 3'd3;
         m1_in = d40 << 8;
      end else if (|d40[23:16]) begin
         g_in  = 3'd2;
         m1_in = d40 << 16;
      end else if (|d40[15:8]) begin
         g_in  = 3'd1;
         m1_in = d40 << 24;
      end else begin
         g_in  = 3'd0;
         m1_in = d40 << 32;
      end
   end

   // Fine normalization within the top byte, then the table index.
   always_comb begin
      j = 3'd0;
      for (int i = 0; i < 8; i++) begin
         if (m1_ff[32+i]) begin
            j = 3'(i);
         end
      end
      mn     = m1_ff << (3'd7 - j);
      p_in   = {g_ff, j};
      idx_in = mn[38:31];
   end

   // Logarithm from exponent and table, then ln and the basis magnitude.
   always_comb begin
      pm      = $signed({1'b0, p_ff}) - 7'sd32;
      lg      = $signed({pm, 30'b0}) + $signed({7'b0, tps_pkg::LOG_TAB[idx_ff]});
      ln      = lgp_ff[tps_pkg::LG_W+tps_pkg::COEF_W -: tps_pkg::LN_W];
      lmag    = ln[tps_pkg::LN_W-1] ? (tps_pkg::LN_W-1)'(-ln) : ln[tps_pkg::LN_W-2:0];
      mag_sum = 46'(dhl_ff) + 46'(dll_ff >> tps_pkg::FRAC_BITS);
      mag     = tps_pkg::MAG_W'(mag_sum >> (tps_pkg::FRAC_BITS + 1));
      if (zero_ff) begin
         u_in = '0;
      end else if (lneg_ff) begin
         u_in = -$signed({1'b0, mag});
      end else begin
         u_in = $signed({1'b0, mag});
      end
      udiff   = (tps_pkg::U_W+1)'(u_ff) - (tps_pkg::U_W+1)'(u0_ff);
      aff_sum = tps_pkg::ACC_W'(cfg_offset)
              + tps_pkg::ACC_W'(px_ff >>> tps_pkg::FRAC_BITS)
              + tps_pkg::ACC_W'(py_ff >>> tps_pkg::FRAC_BITS);
   end

   // Saturation of the final sum to 32 bits.
   always_comb begin
      if (!acc_ff[tps_pkg::ACC_W-1] && (|acc_ff[tps_pkg::ACC_W-2:tps_pkg::OUT_W-1])) begin
         out_value_in = {1'b0, {(tps_pkg::OUT_W-1){1'b1}}};
         out_sat_in   = 1'b1;
      end else if (acc_ff[tps_pkg::ACC_W-1] && !(&acc_ff[tps_pkg::ACC_W-2:tps_pkg::OUT_W-1])) begin
         out_value_in = {1'b1, {(tps_pkg::OUT_W-1){1'b0}}};
         out_sat_in   = 1'b1;
      end else begin
         out_value_in = acc_ff[tps_pkg::OUT_W-1:0];
         out_sat_in   = 1'b0;
      end
   end

   // Basis term pipeline; each stage settles while the controller holds the point.
   always_ff @(posedge clock) begin
      px_ff   <= cfg_gain_x * x_ff;
      py_ff   <= cfg_gain_y * y_ff;
      dx2_ff  <= dx2_full[tps_pkg::D_W-2:0];
      dy2_ff  <= dy2_full[tps_pkg::D_W-2:0];
      d_ff    <= tps_pkg::D_W'(dx2_ff) + tps_pkg::D_W'(dy2_ff);
      m1_ff   <= m1_in;
      g_ff    <= g_in;
      zero_ff <= (d_ff == '0);
      p_ff    <= p_in;
      idx_ff  <= idx_in;
      lgp_ff  <= lg * $signed({1'b0, tps_pkg::LN2_Q24});
      dhl_ff  <= 45'(d_ff >> tps_pkg::FRAC_BITS) * 45'(lmag);
      dll_ff  <= 39'(d_ff[tps_pkg::FRAC_BITS-1:0]) * 39'(lmag);
      lneg_ff <= ln[tps_pkg::LN_W-1];
      u_ff    <= u_in;
      term_ff <= cw * udiff;
      if (cmd.take) begin
         x_ff <= in_x;
         y_ff <= in_y;
      end
      if (cmd.take) begin
         u0_ff <= '0;
      end else if (cmd.u0_load) begin
         u0_ff <= u_ff;
      end
      if (cmd.acc_init) begin
         acc_ff <= aff_sum;
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + tps_pkg::ACC_W'(term_ff >>> tps_pkg::FRAC_BITS);
      end
      if (cmd.out_load) begin
         out_value_ff <= out_value_in;
         out_sat_ff   <= out_sat_in;
      end
   end

   // Result word register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (!out_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign status.out_free = !out_valid_ff || !out_stall;
   assign out_valid       = out_valid_ff;
   assign out_value       = out_value_ff;
   assign out_saturated   = out_sat_ff;

endmodule

`default_nettype wire

// File: sv/tps_ctrl.sv
// Controller of the thin plate spline evaluator: sequences the affine part and each control point.
// Depends on tps_pkg; drives tps_datapath through a command struct.
`default_nettype none

module tps_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic                        req_mode,
   output logic                             req_stall,
   input  wire logic [tps_pkg::CNT_W-1:0]   cfg_points,
   input  wire logic                        cfg_reduced,
   input  wire tps_pkg::status_type         status,
   output tps_pkg::cmd_type                 cmd
);

   tps_pkg::state_type               state_ff, state_in;
   logic [tps_pkg::ADDR_W-1:0]       k_ff, k_in;
   logic [tps_pkg::ADDR_W-1:0]       last_ff, last_in;
   logic [tps_pkg::STEP_W-1:0]       step_ff, step_in;
   logic                             red_ff, red_in;
   logic [tps_pkg::CNT_W-1:0]        n;
   logic                             has_points;

   // Points summed, capped at the store depth.
   always_comb begin
      n = (cfg_points > tps_pkg::CNT_W'(tps_pkg::MAX_POINTS))
        ? tps_pkg::CNT_W'(tps_pkg::MAX_POINTS) : cfg_points;
      has_points = cfg_reduced ? (n > tps_pkg::CNT_W'(1)) : (n != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tps_pkg::ST_IDLE;
         k_ff     <= '0;
         last_ff  <= '0;
         step_ff  <= '0;
         red_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         last_ff  <= last_in;
         step_ff  <= step_in;
         red_ff   <= red_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      k_in      = k_ff;
      last_in   = last_ff;
      step_in   = step_ff;
      red_in    = red_ff;
      req_stall = (state_ff != tps_pkg::ST_IDLE);
      cmd       = '0;
      cmd.rd_addr = k_ff;
      case (state_ff)
         tps_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_mode == tps_pkg::MODE_LOAD) begin
                  cmd.mem_wr = 1'b1;
               end else begin
                  cmd.take = 1'b1;
                  state_in = tps_pkg::ST_AFF_MUL;
               end
            end
         end
         tps_pkg::ST_AFF_MUL: begin
            state_in = tps_pkg::ST_AFF_SUM;
         end
         tps_pkg::ST_AFF_SUM: begin
            cmd.acc_init = 1'b1;
            k_in         = '0;
            step_in      = '0;
            red_in       = cfg_reduced;
            last_in      = tps_pkg::ADDR_W'(n - tps_pkg::CNT_W'(1));
            state_in     = has_points ? tps_pkg::ST_POINT : tps_pkg::ST_FINISH;
         end
         tps_pkg::ST_POINT: begin
            cmd.u0_load = (step_ff == tps_pkg::STEP_U0) && red_ff && (k_ff == '0);
            if (step_ff == tps_pkg::STEP_LAST) begin
               cmd.acc_add = !(red_ff && (k_ff == '0));
               step_in     = '0;
               if (k_ff == last_ff) begin
                  state_in = tps_pkg::ST_FINISH;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         tps_pkg::ST_FINISH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = tps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tps_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: sv/thin_plate_spline_eval_top.sv
// Top level of the thin plate spline evaluator: configuration registers and block wiring.
// Depends on tps_pkg, tps_ctrl and tps_datapath.
`default_nettype none

// A load word (mode 0) writes one control point and its weight and gives no
// result. An evaluate word (mode 1) returns offset + gain_x*x + gain_y*y plus one basis term
// per control point in use, saturated to 32 bits with a flag. The sequencer runs each control
// point through a shared basis unit (distance, two-step normalization, table logarithm,
// multiplies), one point after the other; n is the number of points in use, capped at 32.
// In reduced mode slot 0 is one of the n points and only gives the reference term, and a
// count below two runs no points at all. The input is stalled while an evaluation is in
// progress; a finished result waits in an output register.
module thin_plate_spline_eval_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_mode,
   input  wire logic [4:0]                         req_point_index,
   input  wire logic signed [tps_pkg::COORD_W-1:0] req_coord_x,
   input  wire logic signed [tps_pkg::COORD_W-1:0] req_coord_y,
   input  wire logic signed [tps_pkg::COEF_W-1:0]  req_weight,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [tps_pkg::OUT_W-1:0]        rsp_value,
   output logic                                    rsp_saturated,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [4:0]                         csr_paddr,
   input  wire logic [31:0]                        csr_pwdata,
   output logic [31:0]                             csr_prdata,
   output logic                                    csr_pready
);

   logic signed [tps_pkg::COEF_W-1:0] offset_ff, gain_x_ff, gain_y_ff;
   logic [tps_pkg::CNT_W-1:0]         points_ff;
   logic                              reduced_ff;
   logic                              csr_wr;
   logic [2:0]                        csr_idx;
   tps_pkg::cmd_type                  cmd;
   tps_pkg::status_type               status;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff  <= '0;
         gain_x_ff  <= '0;
         gain_y_ff  <= '0;
         points_ff  <= '0;
         reduced_ff <= 1'b0;
      end else if (csr_wr) begin
         case (csr_idx)
            tps_pkg::REG_OFFSET:  offset_ff  <= csr_pwdata[tps_pkg::COEF_W-1:0];
            tps_pkg::REG_GAIN_X:  gain_x_ff  <= csr_pwdata[tps_pkg::COEF_W-1:0];
            tps_pkg::REG_GAIN_Y:  gain_y_ff  <= csr_pwdata[tps_pkg::COEF_W-1:0];
            tps_pkg::REG_POINTS:  points_ff  <= csr_pwdata[tps_pkg::CNT_W-1:0];
            tps_pkg::REG_REDUCED: reduced_ff <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (csr_idx)
         tps_pkg::REG_OFFSET:  csr_prdata = 32'(offset_ff);
         tps_pkg::REG_GAIN_X:  csr_prdata = 32'(gain_x_ff);
         tps_pkg::REG_GAIN_Y:  csr_prdata = 32'(gain_y_ff);
         tps_pkg::REG_POINTS:  csr_prdata = 32'(points_ff);
         tps_pkg::REG_REDUCED: csr_prdata = 32'(reduced_ff);
         default:              csr_prdata = '0;
      endcase
   end

   tps_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_mode    (req_mode),
      .req_stall   (req_stall),
      .cfg_points  (points_ff),
      .cfg_reduced (reduced_ff),
      .status      (status),
      .cmd         (cmd)
   );

   tps_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .wr_addr       (req_point_index[tps_pkg::ADDR_W-1:0]),
      .in_x          (req_coord_x),
      .in_y          (req_coord_y),
      .in_weight     (req_weight),
      .cfg_offset    (offset_ff),
      .cfg_gain_x    (gain_x_ff),
      .cfg_gain_y    (gain_y_ff),
      .out_stall     (rsp_stall),
      .out_valid     (rsp_valid),
      .out_value     (rsp_value),
      .out_saturated (rsp_saturated)
   );

endmodule

`default_nettype wire
